/* hw/rtl/vnth_pkg.sv */
// Constants shared by the terrain height pipeline.
package vnth_pkg;
	localparam int NUM_OCT = 3;
	localparam logic [32:0] RECIP_0 = 33'd32537631;
	localparam logic [32:0] RECIP_1 = 33'd82595525;
	localparam logic [32:0] RECIP_2 = 33'd226050910;
	localparam logic [31:0] SALT_0 = 32'h574f524c;
	localparam logic [31:0] SALT_1 = 32'h48494c4c;
	localparam logic [31:0] SALT_2 = 32'h44455441;
	localparam logic [18:0] WEIGHT_0 = 19'd314573;
	localparam logic [18:0] WEIGHT_1 = 19'd150733;
	localparam logic [18:0] WEIGHT_2 = 19'd36045;
	localparam logic [31:0] HX = 32'h9e3779b9;
	localparam logic [31:0] HZ = 32'h85ebca6b;
	localparam logic [31:0] AV1 = 32'h7feb352d;
	localparam logic [31:0] AV2 = 32'h846ca68b;
	localparam logic [7:0] ADDR_SEED = 8'h00;
endpackage

/* hw/rtl/vnth_octave.sv */
// One noise octave: cell split, corner hashes, smoothstep and bilinear blend.
module vnth_octave import vnth_pkg::*; (
	input  logic               clk,
	input  logic               adv,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_z,
	input  logic        [32:0] recip,
	input  logic        [31:0] key,
	output logic signed [24:0] noise
);
	// stage 1: scaled positions
	logic signed [65:0] px_s1, pz_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1 <= 66'(pos_x * $signed({1'b0, recip}));
			pz_s1 <= 66'(pos_z * $signed({1'b0, recip}));
		end
	end
	logic [31:0] cx, cz;
	logic [15:0] fx, fz;
	assign cx = 32'(px_s1 >>> 48);
	assign cz = 32'(pz_s1 >>> 48);
	assign fx = px_s1[47:32];
	assign fz = pz_s1[47:32];
	// stage 2: lattice products, t^2
	logic [31:0] mx0_s2, mx1_s2, mz0_s2, mz1_s2;
	logic [15:0] fx_s2, fz_s2;
	logic [31:0] tx2_s2, tz2_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			mx0_s2 <= 32'(cx * HX);
			mx1_s2 <= 32'((cx + 32'd1) * HX);
			mz0_s2 <= 32'(cz * HZ);
			mz1_s2 <= 32'((cz + 32'd1) * HZ);
			fx_s2 <= fx;
			fz_s2 <= fz;
			tx2_s2 <= 32'(fx) * 32'(fx);
			tz2_s2 <= 32'(fz) * 32'(fz);
		end
	end
	logic [31:0] v_pre [4];
	assign v_pre[0] = key ^ mx0_s2 ^ mz0_s2;
	assign v_pre[1] = key ^ mx1_s2 ^ mz0_s2;
	assign v_pre[2] = key ^ mx0_s2 ^ mz1_s2;
	assign v_pre[3] = key ^ mx1_s2 ^ mz1_s2;
	// stage 3: first avalanche multiply, smoothstep product
	logic [31:0] h1_s3 [4];
	logic [15:0] sx_s3, sz_s3;
	logic [17:0] gx, gz;
	assign gx = 18'd196608 - {1'b0, fx_s2, 1'b0};
	assign gz = 18'd196608 - {1'b0, fz_s2, 1'b0};
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++)
				h1_s3[i] <= 32'((v_pre[i] ^ (v_pre[i] >> 16)) * AV1);
			sx_s3 <= 16'((50'(tx2_s2) * 50'(gx)) >> 32);
			sz_s3 <= 16'((50'(tz2_s2) * 50'(gz)) >> 32);
		end
	end
	// stage 4: second avalanche multiply
	logic [31:0] h2_s4 [4];
	logic [15:0] sx_s4, sz_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++)
				h2_s4[i] <= 32'((h1_s3[i] ^ (h1_s3[i] >> 15)) * AV2);
			sx_s4 <= sx_s3;
			sz_s4 <= sz_s3;
		end
	end
	logic signed [24:0] cv [4];
	always_comb begin
		for (int i = 0; i < 4; i++)
			cv[i] = $signed({1'b0, h2_s4[i][23:0] ^ 24'(h2_s4[i] >> 16)}) - 25'sd8388608;
	end
	// stage 5: row blends
	logic signed [24:0] nv_s5, fv_s5;
	logic [15:0] sz_s5;
	logic signed [42:0] dn, df;
	assign dn = 43'(cv[1] - cv[0]) * $signed({1'b0, sx_s4});
	assign df = 43'(cv[3] - cv[2]) * $signed({1'b0, sx_s4});
	always_ff @(posedge clk) begin
		if (adv) begin
			nv_s5 <= cv[0] + 25'(dn >>> 16);
			fv_s5 <= cv[2] + 25'(df >>> 16);
			sz_s5 <= sz_s4;
		end
	end
	// stage 6: column blend
	logic signed [42:0] dc;
	assign dc = 43'(fv_s5 - nv_s5) * $signed({1'b0, sz_s5});
	always_ff @(posedge clk) begin
		if (adv)
			noise <= nv_s5 + 25'(dc >>> 16);
	end
endmodule

/* hw/rtl/value_noise_terrain_height_unit.sv */
// Three-octave value noise terrain height unit, top level.
// An input beat passes the octave stages, the weight register and the height register to the result beat.
// Throughput: one point per cycle; the pipeline holds as a whole on stall.
// Reset: arst_n clears the valid bits and the seed register to zero.
// A result waiting at the output holds the pipeline only while stalled.
module value_noise_terrain_height_unit import vnth_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] height,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic        [0:0]  paddr,
	input  logic        [31:0] pwdata,
	output logic        [31:0] prdata,
	output logic               pready
);
	logic [31:0] seed_q;
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_SEED[0:0]) ? seed_q : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seed_q <= 32'd0;
		else if (psel && penable && pwrite && paddr == ADDR_SEED[0:0])
			seed_q <= pwdata;
	end

	localparam int DEPTH = 8;
	logic [DEPTH-1:0] vld_q;
	logic adv;
	assign adv = !(vld_q[DEPTH-1] && out_stall);
	assign in_stall = !adv;
	assign out_valid = vld_q[DEPTH-1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[DEPTH-2:0], in_valid};
	end

	logic signed [24:0] n0, n1, n2;
	vnth_octave u_oct0 (.clk, .adv, .pos_x, .pos_z, .recip(RECIP_0),
		.key(seed_q ^ SALT_0), .noise(n0));
	vnth_octave u_oct1 (.clk, .adv, .pos_x, .pos_z, .recip(RECIP_1),
		.key(seed_q ^ SALT_1), .noise(n1));
	vnth_octave u_oct2 (.clk, .adv, .pos_x, .pos_z, .recip(RECIP_2),
		.key(seed_q ^ SALT_2), .noise(n2));

	// weight each octave, then sum, round and clamp to 16 bits
	logic signed [44:0] w0_s7, w1_s7, w2_s7;
	always_ff @(posedge clk) begin
		if (adv) begin
			w0_s7 <= 45'(n0) * $signed({1'b0, WEIGHT_0});
			w1_s7 <= 45'(n1) * $signed({1'b0, WEIGHT_1});
			w2_s7 <= 45'(n2) * $signed({1'b0, WEIGHT_2});
		end
	end
	logic signed [46:0] sum;
	logic signed [19:0] h;
	assign sum = 47'(w0_s7) + 47'(w1_s7) + 47'(w2_s7) + 47'sd67108864;
	assign h = 20'(sum >>> 27);
	always_ff @(posedge clk) begin
		if (adv) begin
			if (h > 20'sd32767)
				height <= 16'sd32767;
			else if (h < -20'sd32768)
				height <= -16'sd32768;
			else
				height <= 16'(h);
		end
	end
endmodule
